// File: rtl/core/nit_pkg.sv
`default_nettype none

package nit_pkg;

    localparam int POS_W    = 32;
    localparam int LEN_W    = 32;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int REV_W    = 32;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET_SEL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLR_SEL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_SEL = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLR_ALL = 3'd5;
    localparam logic [CMD_W-1:0] CMD_LOOKUP  = 3'd6;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CONFLICT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;
        logic [LEN_W-1:0] len;
        logic             selected;
    } nit_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    mark_len;
        logic                mark_selected;
        logic [REV_W-1:0]    revision;
    } nit_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/nit_ram.sv
`default_nettype none

module nit_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  wr_en,
    input  wire logic [ADDR_W-1:0]     wr_addr,
    input  wire logic [WIDTH-1:0]      wr_data,
    input  wire logic                  rd_en,
    input  wire logic [ADDR_W-1:0]     rd_addr,
    output logic      [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/non_overlapping_interval_table.sv
`default_nettype none

// Channel  Handshake               Payload     Carries
// req      req_valid / req_stall   nit_req_t   one command: cmd, pos, len, selected
// rsp      rsp_valid / rsp_stall   nit_rsp_t   status, mark_len, mark_selected, revision
//
// Each request passes through the accept state, a scan that walks the
// start/length RAM one entry per cycle through its single registered read
// port, the overlap compare and the commit; the commit waits while an
// earlier response is still stalled. Reset empties the table at once
// through per-entry valid bits. A stalled response holds in the output
// register while the next request is taken and scanned.

module non_overlapping_interval_table
    import nit_pkg::*;
#(
    parameter int ENTRIES = 32
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire nit_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output nit_rsp_t      rsp
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int RAM_W = POS_W + LEN_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_CHECK  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    nit_req_t cur_reg, cur_next;

    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [ENTRIES-1:0] sel_reg, sel_next;
    logic [REV_W-1:0]   rev_reg, rev_next;

    logic [CW-1:0] issue_cnt_reg, issue_cnt_next;
    logic          pipe_vld_reg, pipe_vld_next;
    logic [IW-1:0] pipe_idx_reg, pipe_idx_next;

    logic             found_reg, found_next;
    logic [IW-1:0]    found_idx_reg, found_idx_next;
    logic [LEN_W-1:0] found_len_reg, found_len_next;
    logic             free_vld_reg, free_vld_next;
    logic [IW-1:0]    free_idx_reg, free_idx_next;
    logic             next_vld_reg, next_vld_next;
    logic [POS_W-1:0] next_start_reg, next_start_next;
    logic             prev_vld_reg, prev_vld_next;
    logic [POS_W-1:0] prev_start_reg, prev_start_next;
    logic [LEN_W-1:0] prev_len_reg, prev_len_next;
    logic             any_sel_reg, any_sel_next;
    logic             conflict_reg, conflict_next;

    logic     rsp_valid_reg, rsp_valid_next;
    nit_rsp_t rsp_reg, rsp_next;

    logic             issue_done;
    logic             ram_rd_en;
    logic             ram_wr_en;
    logic [RAM_W-1:0] ram_rd_data;
    logic [POS_W-1:0] e_start;
    logic [LEN_W-1:0] e_len;
    logic             e_live;
    logic [POS_W:0]   eff_len;
    logic [POS_W:0]   new_end;
    logic [POS_W:0]   prev_end;
    logic             finish_go;

    assign issue_done = (issue_cnt_reg == CW'(ENTRIES));
    assign ram_rd_en  = (state_reg == S_SCAN) && !issue_done;
    assign e_start    = ram_rd_data[RAM_W-1:LEN_W];
    assign e_len      = ram_rd_data[LEN_W-1:0];
    assign e_live     = pipe_vld_reg && valid_reg[pipe_idx_reg];
    assign finish_go  = (state_reg == S_FINISH) && !(rsp_valid_reg && rsp_stall);
    assign ram_wr_en  = finish_go && (cur_reg.cmd == CMD_INSERT)
                        && !conflict_reg && free_vld_reg;

    // A zero length still occupies one position for the overlap test.
    assign eff_len  = (cur_reg.len == '0) ? (POS_W+1)'(1) : {1'b0, cur_reg.len};
    assign new_end  = {1'b0, cur_reg.pos} + eff_len;
    assign prev_end = {1'b0, prev_start_reg} + {1'b0, prev_len_reg};

    nit_ram #(
        .WIDTH (RAM_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (free_idx_reg),
        .wr_data ({cur_reg.pos, cur_reg.len}),
        .rd_en   (ram_rd_en),
        .rd_addr (issue_cnt_reg[IW-1:0]),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        valid_next      = valid_reg;
        sel_next        = sel_reg;
        rev_next        = rev_reg;
        issue_cnt_next  = issue_cnt_reg;
        pipe_vld_next   = ram_rd_en;
        pipe_idx_next   = issue_cnt_reg[IW-1:0];
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        found_len_next  = found_len_reg;
        free_vld_next   = free_vld_reg;
        free_idx_next   = free_idx_reg;
        next_vld_next   = next_vld_reg;
        next_start_next = next_start_reg;
        prev_vld_next   = prev_vld_reg;
        prev_start_next = prev_start_reg;
        prev_len_next   = prev_len_reg;
        any_sel_next    = any_sel_reg;
        conflict_next   = conflict_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_next        = rsp_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cur_next       = req;
                    issue_cnt_next = '0;
                    found_next     = 1'b0;
                    free_vld_next  = 1'b0;
                    next_vld_next  = 1'b0;
                    prev_vld_next  = 1'b0;
                    any_sel_next   = 1'b0;
                    state_next     = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (!issue_done)
                begin
                    issue_cnt_next = issue_cnt_reg + CW'(1);
                end
                // The entry read last cycle is judged here.
                if (pipe_vld_reg && !valid_reg[pipe_idx_reg] && !free_vld_reg)
                begin
                    free_vld_next = 1'b1;
                    free_idx_next = pipe_idx_reg;
                end
                if (e_live)
                begin
                    if (e_start == cur_reg.pos)
                    begin
                        found_next     = 1'b1;
                        found_idx_next = pipe_idx_reg;
                        found_len_next = e_len;
                    end
                    if (sel_reg[pipe_idx_reg])
                    begin
                        any_sel_next = 1'b1;
                    end
                    if (e_start >= cur_reg.pos)
                    begin
                        if (!next_vld_reg || (e_start < next_start_reg))
                        begin
                            next_vld_next   = 1'b1;
                            next_start_next = e_start;
                        end
                    end
                    else if (!prev_vld_reg || (e_start > prev_start_reg))
                    begin
                        prev_vld_next   = 1'b1;
                        prev_start_next = e_start;
                        prev_len_next   = e_len;
                    end
                end
                if (issue_done)
                begin
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                conflict_next = (next_vld_reg && ({1'b0, next_start_reg} < new_end))
                                || (prev_vld_reg && (prev_end > {1'b0, cur_reg.pos}));
                state_next    = S_FINISH;
            end

            S_FINISH:
            begin
                if (finish_go)
                begin
                    rsp_next.status        = ST_MISSING;
                    rsp_next.mark_len      = '0;
                    rsp_next.mark_selected = 1'b0;

                    unique case (cur_reg.cmd)
                        CMD_INSERT:
                        begin
                            if (conflict_reg)
                            begin
                                rsp_next.status = ST_CONFLICT;
                            end
                            else if (!free_vld_reg)
                            begin
                                rsp_next.status = ST_FULL;
                            end
                            else
                            begin
                                valid_next[free_idx_reg] = 1'b1;
                                sel_next[free_idx_reg]   = cur_reg.selected;
                                rev_next                 = rev_reg + REV_W'(1);
                                rsp_next.status          = ST_DONE;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (found_reg)
                            begin
                                valid_next[found_idx_reg] = 1'b0;
                                sel_next[found_idx_reg]   = 1'b0;
                                rev_next                  = rev_reg + REV_W'(1);
                                rsp_next.status           = ST_DONE;
                            end
                        end
                        CMD_SET_SEL:
                        begin
                            if (found_reg)
                            begin
                                sel_next[found_idx_reg] = cur_reg.selected;
                                rsp_next.status         = ST_DONE;
                            end
                        end
                        CMD_CLR_SEL:
                        begin
                            sel_next        = '0;
                            rsp_next.status = ST_DONE;
                        end
                        CMD_DEL_SEL:
                        begin
                            if (any_sel_reg)
                            begin
                                // Selection bits are only ever set on live entries.
                                valid_next      = valid_reg & ~sel_reg;
                                sel_next        = '0;
                                rev_next        = rev_reg + REV_W'(1);
                                rsp_next.status = ST_DONE;
                            end
                        end
                        CMD_CLR_ALL:
                        begin
                            valid_next      = '0;
                            sel_next        = '0;
                            rev_next        = rev_reg + REV_W'(1);
                            rsp_next.status = ST_DONE;
                        end
                        CMD_LOOKUP:
                        begin
                            if (found_reg)
                            begin
                                rsp_next.mark_len      = found_len_reg;
                                rsp_next.mark_selected = sel_reg[found_idx_reg];
                                rsp_next.status        = ST_DONE;
                            end
                        end
                        default:
                        begin
                            rsp_next.status = ST_MISSING;
                        end
                    endcase

                    rsp_next.revision = rev_next;
                    rsp_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            sel_reg       <= '0;
            rev_reg       <= '0;
            issue_cnt_reg <= '0;
            pipe_vld_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            sel_reg       <= sel_next;
            rev_reg       <= rev_next;
            issue_cnt_reg <= issue_cnt_next;
            pipe_vld_reg  <= pipe_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        pipe_idx_reg   <= pipe_idx_next;
        found_reg      <= found_next;
        found_idx_reg  <= found_idx_next;
        found_len_reg  <= found_len_next;
        free_vld_reg   <= free_vld_next;
        free_idx_reg   <= free_idx_next;
        next_vld_reg   <= next_vld_next;
        next_start_reg <= next_start_next;
        prev_vld_reg   <= prev_vld_next;
        prev_start_reg <= prev_start_next;
        prev_len_reg   <= prev_len_next;
        any_sel_reg    <= any_sel_next;
        conflict_reg   <= conflict_next;
        rsp_reg        <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// File: tb/sv/non_overlapping_interval_table_tb.sv
`timescale 1ns / 1ps

module non_overlapping_interval_table_tb;
    import nit_pkg::*;

    localparam int ENTRIES        = 32;
    localparam int TOTAL_REQUESTS = 1450;
    localparam int SCRIPT_ROWS    = 25;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 2 * (ENTRIES + 4);
    localparam int REPORT_LIMIT   = 100;
    localparam longint WATCHDOG_NS = 64'd8_000_000;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
    localparam logic [POS_W-1:0] POS_MAX    = 32'hFFFF_FFFF;
    localparam logic [LEN_W-1:0] LEN_MAX    = 32'hFFFF_FFFF;

    typedef enum int {EP_CLUSTER, EP_FILL, EP_EDGE, EP_NOISE} episode_e;
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_CHUNKS} stall_mode_e;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [POS_W-1:0]    pos;
        logic [LEN_W-1:0]    len;
        logic                sel;
        logic                chk;
        logic [STATUS_W-1:0] status;
        logic [REV_W-1:0]    rev;
    } script_row_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    nit_req_t req = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    nit_rsp_t rsp;

    // Mirror of the mark table.
    bit               tbl_valid [ENTRIES];
    logic [POS_W-1:0] tbl_start [ENTRIES];
    logic [LEN_W-1:0] tbl_len   [ENTRIES];
    bit               tbl_sel   [ENTRIES];
    logic [REV_W-1:0] tbl_rev;

    nit_rsp_t table_replies_due[$];

    int mismatches = 0;
    int replies_checked = 0;
    int accepted = 0;
    int long_holds = 0;
    int peak_fill = 0;
    int cmd_seen [8];
    int status_seen [4];

    episode_e         ep_mode = EP_CLUSTER;
    int               ep_left = 0;
    logic [POS_W-1:0] ep_base = '0;
    logic [POS_W-1:0] ep_cursor = '0;

    // Walked in order right after reset. Rows with chk set carry a reply that is
    // obvious by hand; the rest are checked against the table mirror.
    script_row_t script [SCRIPT_ROWS] = '{
        '{CMD_LOOKUP,  32'h0,         32'h0,         1'b0, 1'b1, ST_MISSING,  32'd0},
        '{CMD_DELETE,  32'hFFFF_FFFF, 32'h0,         1'b0, 1'b1, ST_MISSING,  32'd0},
        '{CMD_SET_SEL, 32'h5,         32'h0,         1'b1, 1'b1, ST_MISSING,  32'd0},
        '{CMD_DEL_SEL, 32'h0,         32'h0,         1'b0, 1'b1, ST_MISSING,  32'd0},
        '{CMD_CLR_SEL, 32'h0,         32'h0,         1'b0, 1'b1, ST_DONE,     32'd0},
        '{CMD_CLR_ALL, 32'h0,         32'h0,         1'b0, 1'b1, ST_DONE,     32'd1},
        '{CMD_UNUSED,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, ST_MISSING,  32'd1},
        '{CMD_INSERT,  32'h0,         32'h0,         1'b1, 1'b1, ST_DONE,     32'd2},
        '{CMD_INSERT,  32'h0,         32'h5,         1'b0, 1'b1, ST_CONFLICT, 32'd2},
        '{CMD_INSERT,  32'h1,         32'h0,         1'b0, 1'b0, ST_DONE,     32'd0},
        '{CMD_LOOKUP,  32'h0,         32'h0,         1'b0, 1'b0, ST_DONE,     32'd0},
        '{CMD_INSERT,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, ST_DONE,     32'd0},
        '{CMD_INSERT,  32'hFFFF_FFF0, 32'h10,        1'b0, 1'b1, ST_CONFLICT, 32'd4},
        '{CMD_INSERT,  32'hFFFF_FFF0, 32'hF,         1'b0, 1'b0, ST_DONE,     32'd0},
        '{CMD_INSERT,  32'd100,       32'hFFFF_FFFF, 1'b0, 1'b1, ST_CONFLICT, 32'd5},
        '{CMD_INSERT,  32'd10,        32'd20,        1'b0, 1'b0, ST_DONE,     32'd0},
        '{CMD_INSERT,  32'd29,        32'd1,         1'b0, 1'b0, ST_DONE,     32'd0},
        '{CMD_INSERT,  32'd30,        32'd0,         1'b1, 1'b0, ST_DONE,     32'd0},
        '{CMD_LOOKUP,  32'hFFFF_FFFF, 32'h0,         1'b0, 1'b0, ST_DONE,     32'd0},
        '{CMD_SET_SEL, 32'd10,        32'h0,         1'b1, 1'b0, ST_DONE,     32'd0},
        '{CMD_LOOKUP,  32'd30,        32'h0,         1'b0, 1'b0, ST_DONE,     32'd0},
        '{CMD_DEL_SEL, 32'h0,         32'h0,         1'b0, 1'b0, ST_DONE,     32'd0},
        '{CMD_LOOKUP,  32'd10,        32'h0,         1'b0, 1'b0, ST_DONE,     32'd0},
        '{CMD_DELETE,  32'd1,         32'h0,         1'b0, 1'b0, ST_DONE,     32'd0},
        '{CMD_DELETE,  32'd1,         32'h0,         1'b0, 1'b1, ST_MISSING,  32'd9}
    };

    non_overlapping_interval_table #(
        .ENTRIES(ENTRIES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_sel[i] = 1'b0;
        end
        tbl_rev = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic int slot_of(logic [POS_W-1:0] p);
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && tbl_start[i] == p)
                return i;
        return -1;
    endfunction

    // Applies one request to the mirror and returns the reply it must produce.
    function automatic nit_rsp_t table_execute(nit_req_t r);
        nit_rsp_t o;
        int k;
        int nxt;
        int prv;
        int fill;
        logic [POS_W:0] reach;
        bit blocked;
        o.status = ST_MISSING;
        o.mark_len = '0;
        o.mark_selected = 1'b0;
        case (r.cmd)
            CMD_INSERT:
            begin
                nxt = -1;
                prv = -1;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (tbl_valid[i])
                    begin
                        if (tbl_start[i] >= r.pos)
                        begin
                            if (nxt < 0 || tbl_start[i] < tbl_start[nxt])
                                nxt = i;
                        end
                        else if (prv < 0 || tbl_start[i] > tbl_start[prv])
                            prv = i;
                    end
                end
                // A zero length still claims one sample for the overlap test.
                reach = {1'b0, r.pos} + ((r.len == '0) ? 33'd1 : {1'b0, r.len});
                blocked = (nxt >= 0 && {1'b0, tbl_start[nxt]} < reach) ||
                          (prv >= 0 && {1'b0, tbl_start[prv]} + {1'b0, tbl_len[prv]} >
                           {1'b0, r.pos});
                if (blocked)
                    o.status = ST_CONFLICT;
                else
                begin
                    o.status = ST_FULL;
                    k = -1;
                    for (int i = 0; i < ENTRIES; i++)
                        if (k < 0 && !tbl_valid[i])
                            k = i;
                    if (k >= 0)
                    begin
                        tbl_valid[k] = 1'b1;
                        tbl_start[k] = r.pos;
                        tbl_len[k] = r.len;
                        tbl_sel[k] = r.selected;
                        tbl_rev = tbl_rev + 1'b1;
                        o.status = ST_DONE;
                        fill = 0;
                        for (int i = 0; i < ENTRIES; i++)
                            fill += tbl_valid[i];
                        if (fill > peak_fill)
                            peak_fill = fill;
                    end
                end
            end
            CMD_DELETE:
            begin
                k = slot_of(r.pos);
                if (k >= 0)
                begin
                    tbl_valid[k] = 1'b0;
                    tbl_sel[k] = 1'b0;
                    tbl_rev = tbl_rev + 1'b1;
                    o.status = ST_DONE;
                end
            end
            CMD_SET_SEL:
            begin
                k = slot_of(r.pos);
                if (k >= 0)
                begin
                    tbl_sel[k] = r.selected;
                    o.status = ST_DONE;
                end
            end
            CMD_CLR_SEL:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    tbl_sel[i] = 1'b0;
                o.status = ST_DONE;
            end
            CMD_DEL_SEL:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (tbl_valid[i] && tbl_sel[i])
                    begin
                        tbl_valid[i] = 1'b0;
                        tbl_sel[i] = 1'b0;
                        o.status = ST_DONE;
                    end
                end
                if (o.status == ST_DONE)
                    tbl_rev = tbl_rev + 1'b1;
            end
            CMD_CLR_ALL:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    tbl_valid[i] = 1'b0;
                    tbl_sel[i] = 1'b0;
                end
                tbl_rev = tbl_rev + 1'b1;
                o.status = ST_DONE;
            end
            CMD_LOOKUP:
            begin
                k = slot_of(r.pos);
                if (k >= 0)
                begin
                    o.mark_len = tbl_len[k];
                    o.mark_selected = tbl_sel[k];
                    o.status = ST_DONE;
                end
            end
            default:
            begin
            end
        endcase
        o.revision = tbl_rev;
        status_seen[o.status]++;
        return o;
    endfunction

    // Random requests come in episodes: a crowded region, a run that packs the
    // table full, positions and lengths at the ends of the range, and noise.
    function automatic nit_req_t pick_request();
        nit_req_t r;
        int roll;
        int live[$];
        int k;
        if (ep_left == 0)
        begin
            roll = $urandom_range(0, 99);
            ep_mode = (roll < 45) ? EP_CLUSTER : (roll < 65) ? EP_FILL :
                      (roll < 85) ? EP_EDGE : EP_NOISE;
            ep_left = (ep_mode == EP_FILL) ? ENTRIES + 24 : $urandom_range(20, 60);
            ep_base = $urandom;
            ep_cursor = ep_base;
        end
        ep_left--;
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i])
                live.insert(live.size(), i);
        r.selected = 1'($urandom_range(0, 1));
        case (ep_mode)
            EP_CLUSTER:
            begin
                r.pos = ep_base + 32'($urandom_range(0, 400));
                r.len = ($urandom_range(0, 9) == 0) ? '0 : 32'($urandom_range(1, 40));
            end
            EP_FILL:
            begin
                r.pos = ep_cursor;
                r.len = 32'($urandom_range(0, 6));
            end
            EP_EDGE:
            begin
                r.pos = ($urandom_range(0, 1) == 1) ? 32'($urandom_range(0, 64)) :
                        POS_MAX - 32'($urandom_range(0, 64));
                case ($urandom_range(0, 3))
                    0: r.len = '0;
                    1: r.len = 32'($urandom_range(1, 80));
                    2: r.len = LEN_MAX - 32'($urandom_range(0, 80));
                    default: r.len = $urandom;
                endcase
            end
            default:
            begin
                r.pos = $urandom;
                r.len = $urandom;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (ep_mode == EP_NOISE)
            r.cmd = CMD_W'($urandom_range(0, 7));
        else if (ep_mode == EP_FILL && (live.size() < ENTRIES || roll < 30))
            r.cmd = CMD_INSERT;
        else if (roll < 40)
            r.cmd = CMD_INSERT;
        else if (roll < 52)
            r.cmd = CMD_DELETE;
        else if (roll < 64)
            r.cmd = CMD_SET_SEL;
        else if (roll < 67)
            r.cmd = CMD_CLR_SEL;
        else if (roll < 72)
            r.cmd = CMD_DEL_SEL;
        else if (roll < 73)
            r.cmd = CMD_CLR_ALL;
        else if (roll < 97)
            r.cmd = CMD_LOOKUP;
        else
            r.cmd = CMD_UNUSED;
        // Keyed commands mostly hit a live mark; some inserts land on a start
        // or right at the end of one.
        if (ep_mode != EP_NOISE && !(ep_mode == EP_FILL && r.cmd == CMD_INSERT) &&
            live.size() > 0 && $urandom_range(0, 3) < ((r.cmd == CMD_INSERT) ? 1 : 3))
        begin
            k = live[$urandom_range(0, live.size() - 1)];
            if (r.cmd == CMD_INSERT)
                r.pos = tbl_start[k] + (($urandom_range(0, 1) == 1) ? tbl_len[k] :
                                        32'($urandom_range(0, 2)));
            else
                r.pos = tbl_start[k] + 32'($urandom_range(0, 9) == 0);
        end
        if (ep_mode == EP_FILL && r.cmd == CMD_INSERT)
            ep_cursor = ep_cursor + ((r.len == '0) ? 32'd1 : r.len) +
                        32'($urandom_range(0, 3));
        return r;
    endfunction

    task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatches < REPORT_LIMIT)
            $display("MISMATCH at reply %0d: %s got %h want %h", replies_checked, what,
                     got, want);
        mismatches++;
    endtask

    initial
    begin : request_driver
        nit_rsp_t want;
        nit_rsp_t offer_want;
        nit_req_t nxt;
        script_row_t row;
        bit offer_fixed;
        int burst_left;
        int gap_left;
        offer_fixed = 1'b0;
        offer_want = '0;
        burst_left = 0;
        gap_left = 0;
        wait (rst_n === 1'b1);
        while (accepted < TOTAL_REQUESTS)
        begin
            @(posedge clk);
            if (req_valid && !req_stall)
            begin
                want = table_execute(req);
                if (offer_fixed)
                    want = offer_want;
                table_replies_due.insert(table_replies_due.size(), want);
                cmd_seen[req.cmd]++;
                accepted++;
            end
            // A stalled request holds its payload; otherwise pick what comes next.
            if (!(req_valid && req_stall))
            begin
                if (accepted == TOTAL_REQUESTS)
                    req_valid <= 1'b0;
                else if (gap_left > 0)
                begin
                    req_valid <= 1'b0;
                    gap_left--;
                end
                else
                begin
                    if (accepted < SCRIPT_ROWS)
                    begin
                        row = script[accepted];
                        nxt.cmd = row.cmd;
                        nxt.pos = row.pos;
                        nxt.len = row.len;
                        nxt.selected = row.sel;
                        offer_fixed = row.chk;
                        offer_want.status = row.status;
                        offer_want.mark_len = '0;
                        offer_want.mark_selected = 1'b0;
                        offer_want.revision = row.rev;
                    end
                    else
                    begin
                        nxt = pick_request();
                        offer_fixed = 1'b0;
                    end
                    req <= nxt;
                    req_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            gap_left = 0;
                            burst_left = $urandom_range(20, 60);
                        end
                        else
                        begin
                            gap_left = $urandom_range(1, 50);
                            burst_left = $urandom_range(1, 8);
                        end
                    end
                end
            end
        end
        while (table_replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d requests: insert %0d, delete %0d, set-select %0d,",
                 accepted, cmd_seen[CMD_INSERT], cmd_seen[CMD_DELETE], cmd_seen[CMD_SET_SEL],
                 " clear-select %0d, delete-selected %0d, clear-all %0d, lookup %0d,",
                 cmd_seen[CMD_CLR_SEL], cmd_seen[CMD_DEL_SEL], cmd_seen[CMD_CLR_ALL],
                 cmd_seen[CMD_LOOKUP], " code 7 %0d.", cmd_seen[CMD_UNUSED]);
        $display("Peak fill %0d/%0d, %0d full and %0d overlap refusals,",
                 peak_fill, ENTRIES, status_seen[ST_FULL], status_seen[ST_CONFLICT],
                 " %0d long reply hold-offs, revision %0d.", long_holds, tbl_rev);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : reply_stall
        int seg;
        int seg_len;
        stall_mode_e mode;
        seg = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            seg++;
            if (seg % 17 == 5)
            begin
                // Long hold-off: one reply parks at the output, the next request is
                // scanned behind it, and then the block must stall its input.
                repeat (HOLD_CYCLES)
                begin
                    @(posedge clk);
                    rsp_stall <= 1'b1;
                end
                long_holds++;
            end
            else
            begin
                mode = stall_mode_e'($urandom_range(0, 3));
                seg_len = $urandom_range(20, 200);
                for (int c = 0; c < seg_len; c++)
                begin
                    @(posedge clk);
                    case (mode)
                        STALL_NONE: rsp_stall <= 1'b0;
                        STALL_LIGHT: rsp_stall <= ($urandom_range(0, 99) < 30);
                        STALL_HEAVY: rsp_stall <= ($urandom_range(0, 99) < 70);
                        default: rsp_stall <= ((c / 40) % 2 == 1);
                    endcase
                end
            end
        end
    end

    always @(posedge clk)
    begin : reply_checker
        nit_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (table_replies_due.size() == 0)
                note_mismatch("reply with no request outstanding, revision", rsp.revision, '0);
            else
            begin
                want = table_replies_due.pop_front();
                if (rsp.status !== want.status)
                    note_mismatch("status", 32'(rsp.status), 32'(want.status));
                if (rsp.mark_len !== want.mark_len)
                    note_mismatch("mark_len", rsp.mark_len, want.mark_len);
                if (rsp.mark_selected !== want.mark_selected)
                    note_mismatch("mark_selected", 32'(rsp.mark_selected),
                                  32'(want.mark_selected));
                if (rsp.revision !== want.revision)
                    note_mismatch("revision", rsp.revision, want.revision);
            end
            replies_checked++;
        end
    end

    initial
    begin : watchdog
        #(WATCHDOG_NS);
        $display("Timed out with %0d of %0d requests taken, %0d replies outstanding.",
                 accepted, TOTAL_REQUESTS, table_replies_due.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
